// ----- rtl/bsfr_pkg.sv -----
// shared types and constants for the byte-stuffed frame receiver
// no dependencies; used by bsfr_front, bsfr_back and the top level in rtl
package bsfr_pkg;

  // line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h5e;
  localparam logic [7:0] ESC_ESC   = 8'h5d;

  // field widths
  localparam int BYTE_W = 8;
  localparam int CHAN_W = 3;
  localparam int CNT_W  = 8;
  localparam int LEN_W  = 7;
  localparam int NEED_W = BYTE_W + 1;

  // readout finished on one buffer bank
  typedef struct packed {
    logic valid;
    logic bank;
  } bsfr_done_t;

endpackage

// ----- rtl/bsfr_ram.sv -----
// two-bank frame buffer: one write port, one registered read port
// depends on nothing; read data holds while the read enable is low
module bsfr_ram #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bsfr_fifo.sv -----
// two-entry queue of readout commands between front and back
// depends on nothing
module bsfr_fifo #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/bsfr_front.sv -----
// receive front: unstuffing, sum check, close test, pending frame and bank control
// depends on bsfr_pkg; writes bsfr_ram and pushes commands into bsfr_fifo
module bsfr_front #(
  parameter int FRAME_BYTES = 64,
  parameter int CW          = 7,
  parameter int AW          = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req,
  input  logic [7:0]                in_byte,
  input  logic [2:0]                in_chan,
  output logic                      ram_we,
  output logic [AW:0]               ram_waddr,
  output logic [7:0]                ram_wdata,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic                      cmd_bank,
  output logic [CW-1:0]             cmd_len,
  output logic [2:0]                cmd_chan,
  output logic [7:0]                cmd_cnt,
  input  bsfr_pkg::bsfr_done_t      done
);

  logic [7:0]    station;
  logic          in_frame;
  logic [CW-1:0] byte_count;
  logic [7:0]    running_sum;
  logic [CW-1:0] last_unstuff;
  logic [7:0]    prev_byte;
  logic [7:0]    byte0;
  logic [7:0]    byte1;
  logic          pending_valid;
  logic [CW-1:0] pending_len;
  logic [2:0]    pending_chan;
  logic [7:0]    accept_counter;
  logic          asm_bank;
  logic [1:0]    locked;

  logic                        take;
  logic                        take_byte;
  logic [bsfr_pkg::NEED_W-1:0] need;
  logic                        close;
  logic                        full;
  logic                        esc;
  logic                        esc_flag;
  logic                        esc_esc;
  logic [CW-1:0]               bc_m1;

  // handshake: bytes wait while their bank is being read out
  assign in_ready  = in_req ? (!pending_valid || push_ready) : !locked[asm_bank];
  assign take      = in_valid && in_ready;
  assign take_byte = take && !in_req;

  // close test and escape detection
  assign need  = bsfr_pkg::NEED_W'(byte0) + bsfr_pkg::NEED_W'(1);
  assign close = in_frame && (in_byte == bsfr_pkg::FLAG_BYTE) && (byte_count != '0) &&
                 (bsfr_pkg::NEED_W'(byte_count) >= need) &&
                 (running_sum == {prev_byte[6:0], 1'b0}) && (byte1 == station);
  assign full     = (byte_count >= CW'(FRAME_BYTES));
  assign esc      = (byte_count != '0) && (prev_byte == bsfr_pkg::ESC_BYTE) &&
                    (last_unstuff != byte_count);
  assign esc_flag = esc && (in_byte == bsfr_pkg::ESC_FLAG);
  assign esc_esc  = esc && (in_byte == bsfr_pkg::ESC_ESC);
  assign bc_m1    = byte_count - CW'(1);

  // buffer write: stored byte, or the escape replaced by a flag
  assign ram_we    = take_byte && in_frame && !close && !full && !esc_esc;
  assign ram_waddr = esc_flag ? {asm_bank, bc_m1[AW-1:0]} : {asm_bank, byte_count[AW-1:0]};
  assign ram_wdata = esc_flag ? bsfr_pkg::FLAG_BYTE : in_byte;

  // readout command for the pending bank
  assign push_valid = take && in_req && pending_valid;
  assign cmd_bank   = ~asm_bank;
  assign cmd_len    = pending_len;
  assign cmd_chan   = pending_chan;
  assign cmd_cnt    = accept_counter;

  // station address register
  always_ff @(posedge clk) begin
    if (rst) begin
      station <= 8'h00;
    end else if (cfg_we) begin
      station <= cfg_wdata;
    end
  end

  // frame reception and pending control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_count     <= '0;
      running_sum    <= 8'h00;
      last_unstuff   <= '0;
      pending_valid  <= 1'b0;
      accept_counter <= 8'h00;
      asm_bank       <= 1'b0;
    end else begin
      if (take_byte) begin
        if (!in_frame) begin
          in_frame     <= (in_byte == bsfr_pkg::FLAG_BYTE);
          byte_count   <= '0;
          running_sum  <= 8'h00;
          last_unstuff <= '0;
        end else if (close || full) begin
          in_frame     <= 1'b0;
          byte_count   <= '0;
          running_sum  <= 8'h00;
          last_unstuff <= '0;
          if (close && !pending_valid) begin
            pending_valid  <= 1'b1;
            accept_counter <= accept_counter + 8'd1;
            asm_bank       <= ~asm_bank;
          end
        end else if (esc_flag) begin
          last_unstuff <= byte_count;
          running_sum  <= running_sum + 8'd1;
        end else if (esc_esc) begin
          last_unstuff <= byte_count;
        end else if (in_byte == bsfr_pkg::FLAG_BYTE) begin
          // flag taken as data, then the frame restarts
          in_frame     <= 1'b1;
          byte_count   <= '0;
          running_sum  <= 8'h00;
          last_unstuff <= '0;
        end else begin
          byte_count  <= byte_count + CW'(1);
          running_sum <= running_sum + in_byte;
        end
      end
      if (push_valid) begin
        pending_valid <= 1'b0;
      end
    end
  end

  // shadows of buffer entries 0, 1 and the latest stored one, plus pending payload
  always_ff @(posedge clk) begin
    if (take_byte && in_frame && !close && !full) begin
      if (byte_count == CW'(0)) byte0 <= in_byte;
      if (byte_count == CW'(1)) byte1 <= in_byte;
      if (esc_flag) begin
        prev_byte <= bsfr_pkg::FLAG_BYTE;
        if (byte_count == CW'(1)) byte0 <= bsfr_pkg::FLAG_BYTE;
        if (byte_count == CW'(2)) byte1 <= bsfr_pkg::FLAG_BYTE;
      end else if (!esc_esc) begin
        prev_byte <= in_byte;
      end
    end
    if (take_byte && close && !pending_valid) begin
      pending_len  <= need[CW-1:0];
      pending_chan <= in_chan;
    end
  end

  // banks under readout are locked against new writes
  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= 2'b00;
    end else begin
      if (done.valid) locked[done.bank] <= 1'b0;
      if (push_valid) locked[~asm_bank] <= 1'b1;
    end
  end

  write_bank_unlocked: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !locked[asm_bank])
    else $error("buffer write into a bank under readout");

  release_clears_pending: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> !pending_valid)
    else $error("pending frame still marked after release");

endmodule

// ----- rtl/bsfr_back.sv -----
// readout back end: streams a pending frame out of the buffer, one word a cycle while not stalled by out_ready
// depends on bsfr_pkg; reads bsfr_ram and pops commands from bsfr_fifo
module bsfr_back #(
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 cmd_bank,
  input  logic [CW-1:0]        cmd_len,
  input  logic [2:0]           cmd_chan,
  input  logic [7:0]           cmd_cnt,
  output logic                 ram_re,
  output logic [AW:0]          ram_raddr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  output logic [6:0]           out_len,
  output logic [2:0]           out_chan,
  output logic [7:0]           out_cnt,
  output bsfr_pkg::bsfr_done_t done
);

  logic          active;
  logic          bank;
  logic [AW-1:0] idx;
  logic [CW-1:0] len;
  logic [2:0]    chan;
  logic [7:0]    cnt;
  logic          pop;
  logic          issue;
  logic          last_rd;

  assign cmd_ready = !active;
  assign pop       = cmd_valid && !active;
  assign issue     = active && (!out_valid || out_ready);
  assign last_rd   = (CW'(idx) == (len - CW'(1)));

  assign ram_re     = issue;
  assign ram_raddr  = {bank, idx};
  assign done.valid = issue && last_rd;
  assign done.bank  = bank;

  // command tracking and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (issue && last_rd) begin
        active <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command payload, index and output sidebands
  always_ff @(posedge clk) begin
    if (pop) begin
      bank <= cmd_bank;
      len  <= cmd_len;
      chan <= cmd_chan;
      cnt  <= cmd_cnt;
      idx  <= '0;
    end else if (issue) begin
      idx <= idx + AW'(1);
    end
    if (issue) begin
      out_last <= last_rd;
      out_len  <= 7'(len);
      out_chan <= chan;
      out_cnt  <= cnt;
    end
  end

  last_read_ends_run: assert property (@(posedge clk) disable iff (rst)
    (issue && last_rd) |=> !active)
    else $error("readout still active after its last word");

  run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    pop |=> (active && idx == '0))
    else $error("readout did not start at the first byte");

endmodule

// ----- rtl/byte_stuffed_frame_receiver_unit.sv -----
// top level of the byte-stuffed frame receiver
// depends on bsfr_pkg, bsfr_ram, bsfr_fifo, bsfr_front and bsfr_back
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: rx_byte, source_channel
//  m_*      out  m_tvalid/m_tready  m_tdata: out_byte, frame_length, frame_channel,
//                                   frames_accepted; m_tlast: last
//  cfg_*    in   cfg_we             cfg_wdata: station_address
//
// received bytes are taken one word every cycle, unless their bank is locked
// a release with a frame pending queues a readout command; the back end then streams
// frame_length words, one a cycle while m_tready is high, limited by the single buffer read port
// a byte waits while the buffer bank it would write is still being read out;
// a release with a frame pending waits while the two-entry readout queue is full
// reset clears the control state; the buffer banks need no clearing pass
module byte_stuffed_frame_receiver_unit #(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [10:8] source_channel
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [14:8] frame_length,
                                 // [17:15] frame_channel, [25:18] frames_accepted
  output logic        m_tlast
);

  localparam int CW    = $clog2(FRAME_BYTES + 1);
  localparam int AW    = $clog2(FRAME_BYTES);
  localparam int CMD_W = 1 + CW + bsfr_pkg::CHAN_W + bsfr_pkg::CNT_W;

  logic                 ram_we;
  logic [AW:0]          ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [AW:0]          ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 push_valid;
  logic                 push_ready;
  logic                 f_bank;
  logic [CW-1:0]        f_len;
  logic [2:0]           f_chan;
  logic [7:0]           f_cnt;
  logic [CMD_W-1:0]     q_in;
  logic [CMD_W-1:0]     q_out;
  logic                 q_valid;
  logic                 q_ready;
  logic [6:0]           o_len;
  logic [2:0]           o_chan;
  logic [7:0]           o_cnt;
  bsfr_pkg::bsfr_done_t done;

  // receive front
  bsfr_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .CW(CW),
    .AW(AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_chan   (s_tdata[10:8]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .cmd_bank  (f_bank),
    .cmd_len   (f_len),
    .cmd_chan  (f_chan),
    .cmd_cnt   (f_cnt),
    .done      (done)
  );

  // readout command queue
  assign q_in = {f_bank, f_len, f_chan, f_cnt};

  bsfr_fifo #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push_valid),
    .in_ready (push_ready),
    .in_data  (q_in),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_out)
  );

  // two-bank frame buffer
  bsfr_ram #(
    .ADDR_W(AW + 1)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // readout back end
  bsfr_back #(
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd_bank (q_out[CMD_W-1]),
    .cmd_len  (q_out[CMD_W-2 -: CW]),
    .cmd_chan (q_out[bsfr_pkg::CNT_W +: bsfr_pkg::CHAN_W]),
    .cmd_cnt  (q_out[bsfr_pkg::CNT_W-1:0]),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_last (m_tlast),
    .out_len  (o_len),
    .out_chan (o_chan),
    .out_cnt  (o_cnt),
    .done     (done)
  );

  // output word packing
  assign m_tdata = {6'b0, o_cnt, o_chan, o_len, ram_rdata};

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for byte_stuffed_frame_receiver_unit
// holds its own deframer model and drives bytes and releases with random pacing
// depends on bsfr_pkg and the rtl top level only
`timescale 1ns / 1ps

module testbench;

  localparam int FRAME_LEN   = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 40;
  localparam bit REQ_BYTE    = 1'b0;
  localparam bit REQ_RELEASE = 1'b1;

  typedef bit [7:0] octet_q_t[$];

  // one word of a frame readout
  typedef struct {
    bit [7:0] data;
    bit       last;
    bit [6:0] len;
    bit [2:0] chan;
    bit [7:0] count;
  } readout_t;

  typedef enum {PACE_ALWAYS, PACE_COIN, PACE_SPARSE, PACE_MOSTLY} pace_t;

  // deframer model and store of expected readout words
  class deframer_model;
    bit [7:0] station;
    bit       framing;
    int       count;
    bit [7:0] sum;
    int       unstuff_at;
    bit [7:0] asm_buf[FRAME_LEN];
    bit       held;
    bit [7:0] held_buf[FRAME_LEN];
    int       held_len;
    bit [2:0] held_chan;
    bit [7:0] accepted;
    readout_t readout_q[$];
    int       errors;

    function void restart(bit opening);
      framing    = opening;
      count      = 0;
      sum        = 0;
      unstuff_at = 0;
    endfunction

    // one line byte through the deframer
    function void receive_octet(bit [7:0] d, bit [2:0] ch);
      int need;
      bit closes;
      if (framing) begin
        need   = asm_buf[0] + 1;
        closes = count >= need && count >= 1 &&
                 sum == {asm_buf[count - 1][6:0], 1'b0} &&
                 asm_buf[1] == station && d == bsfr_pkg::FLAG_BYTE;
        if (closes) begin
          // a frame already held: drop the new one, back to idle
          if (held) begin
            framing = 1'b0;
            count   = 0;
            sum     = 0;
            return;
          end
          for (int k = 0; k < count; k++) held_buf[k] = asm_buf[k];
          restart(1'b0);
          held      = 1'b1;
          held_len  = need;
          held_chan = ch;
          accepted  = accepted + 8'd1;
          return;
        end
        // full frame and no close: abort, byte discarded
        if (count >= FRAME_LEN) begin
          restart(1'b0);
          return;
        end
        asm_buf[count] = d;
        if (count >= 1 && asm_buf[count - 1] == bsfr_pkg::ESC_BYTE &&
            unstuff_at != count) begin
          if (d == bsfr_pkg::ESC_FLAG) begin
            unstuff_at         = count;
            asm_buf[count - 1] = bsfr_pkg::FLAG_BYTE;
            sum                = sum + 8'd1;
            return;
          end
          if (d == bsfr_pkg::ESC_ESC) begin
            unstuff_at = count;
            return;
          end
        end
        count++;
        sum = sum + d;
      end else begin
        restart(1'b0);
      end
      if (d == bsfr_pkg::FLAG_BYTE) restart(1'b1);
    endfunction

    // note an accepted input word
    function void note_word(bit req, bit [7:0] d, bit [2:0] ch);
      readout_t r;
      if (req == REQ_BYTE) begin
        receive_octet(d, ch);
        return;
      end
      if (!held) return;
      for (int k = 0; k < held_len; k++) begin
        r.data  = held_buf[k];
        r.last  = (k == held_len - 1);
        r.len   = held_len[6:0];
        r.chan  = held_chan;
        r.count = accepted;
        readout_q.push_back(r);
      end
      held     = 1'b0;
      held_len = 0;
    endfunction

    function int outstanding();
      return readout_q.size();
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (errors < SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    // compare one output word with the oldest expectation
    function void check_word(logic [31:0] w, logic tl);
      readout_t e;
      if (readout_q.size() == 0) begin
        if (errors < SHOW_LIMIT)
          $display("%0t: unexpected word, expected none, got data %h last %b",
                   $time, w, tl);
        errors++;
        return;
      end
      e = readout_q.pop_front();
      if (w[7:0]   !== e.data)  report("out_byte", e.data, w[7:0]);
      if (tl       !== e.last)  report("last", e.last, tl);
      if (w[14:8]  !== e.len)   report("frame_length", e.len, w[14:8]);
      if (w[17:15] !== e.chan)  report("frame_channel", e.chan, w[17:15]);
      if (w[25:18] !== e.count) report("frames_accepted", e.count, w[25:18]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;  // [7:0] rx_byte, [10:8] source_channel
  logic        s_tuser = 1'b0;      // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [7:0] out_byte, [14:8] frame_length,
                          // [17:15] frame_channel, [25:18] frames_accepted
  logic        m_tlast;

  deframer_model model;
  int    burst_left = 0;
  bit    steady = 1'b0;
  int    words_sent = 0;
  int    cycle_count = 0;
  int    pace_tick = 0;
  pace_t pace = PACE_ALWAYS;

  byte_stuffed_frame_receiver_unit #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[byte_stuffed_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  // receiver back-pressure, with a pattern re-picked at random
  always @(posedge clk) begin
    pace_tick++;
    if (pace_tick % 200 == 0) pace = pace_t'($urandom_range(0, 3));
    case (pace)
      PACE_ALWAYS: m_tready <= 1'b1;
      PACE_COIN:   m_tready <= 1'($urandom_range(0, 1));
      PACE_SPARSE: m_tready <= (pace_tick % 4 == 0);
      default:     m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // output word check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_word(m_tdata, m_tlast);
  end

  // byte mix weighted towards the line codes and the extremes
  function automatic bit [7:0] pick_octet();
    case ($urandom_range(0, 9))
      0:       return bsfr_pkg::FLAG_BYTE;
      1:       return bsfr_pkg::ESC_BYTE;
      2:       return bsfr_pkg::ESC_FLAG;
      3:       return bsfr_pkg::ESC_ESC;
      4:       return 8'h00;
      5:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // unstuffed frame: length byte, address, body, sum byte
  function automatic octet_q_t build_frame(int len, bit [7:0] addr, bit good_sum);
    octet_q_t q;
    bit [7:0] acc;
    for (int i = 0; i < len; i++) q.push_back(pick_octet());
    q[0] = ($urandom_range(0, 3) != 0) ? 8'(len - 1) : 8'($urandom_range(0, len - 1));
    q[1] = addr;
    acc  = 8'h00;
    for (int i = 0; i < len - 1; i++) acc = acc + q[i];
    q[len - 1] = good_sum ? acc : acc + 8'd1;
    return q;
  endfunction

  // one word on the input stream, bursts with random gaps
  task automatic send_word(bit req, bit [7:0] d);
    bit [2:0] ch;
    int gap;
    ch = 3'($urandom_range(0, 7));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, ch, d};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    model.note_word(req, d, ch);
    words_sent++;
  endtask

  // frame on the line with byte stuffing, optional stray releases
  task automatic send_frame(octet_q_t body, bit closing, bit mixed);
    send_word(REQ_BYTE, bsfr_pkg::FLAG_BYTE);
    foreach (body[i]) begin
      if (mixed && $urandom_range(0, 39) == 0) send_word(REQ_RELEASE, 8'($urandom));
      if (body[i] == bsfr_pkg::FLAG_BYTE || body[i] == bsfr_pkg::ESC_BYTE) begin
        send_word(REQ_BYTE, bsfr_pkg::ESC_BYTE);
        send_word(REQ_BYTE, body[i] == bsfr_pkg::FLAG_BYTE ? bsfr_pkg::ESC_FLAG
                                                           : bsfr_pkg::ESC_ESC);
      end else begin
        send_word(REQ_BYTE, body[i]);
      end
    end
    if (closing) send_word(REQ_BYTE, bsfr_pkg::FLAG_BYTE);
  endtask

  // hold the input until every readout word has come
  task automatic wait_drained();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_station(bit [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    model.station  = v;
  endtask

  // random frames, good ones mostly, plus broken ones and noise
  task automatic run_random(int upto);
    int kind;
    int len;
    while (words_sent < upto) begin
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 19);
      len    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
      case (kind)
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
          send_frame(build_frame(len, model.station, 1'b1), 1'b1, 1'b1);
        11, 12:
          send_frame(build_frame(len, model.station ^ 8'($urandom_range(1, 255)), 1'b1),
                     1'b1, 1'b1);
        13, 14:
          send_frame(build_frame(len, model.station, 1'b0), 1'b1, 1'b1);
        15:
          send_frame(build_frame(len, model.station, 1'b1), 1'b0, 1'b1);
        16:
          send_frame(build_frame($urandom_range(FRAME_LEN - 2, FRAME_LEN + 3),
                                 model.station, 1'b1), 1'b1, 1'b0);
        default:
          repeat ($urandom_range(1, 8)) send_word(REQ_BYTE, pick_octet());
      endcase
      if ($urandom_range(0, 1)) send_word(REQ_RELEASE, 8'($urandom));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  // stimulus
  initial begin
    bit [7:0] addr_set[5];
    int base;
    model = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty release, shortest frames, stale address byte,
    // stuffed flag and escape, close while a frame is held
    write_station(8'h01);
    send_word(REQ_RELEASE, 8'hff);
    send_frame('{8'h01, 8'h01}, 1'b1, 1'b0);
    send_word(REQ_RELEASE, 8'h00);
    send_frame('{8'h00}, 1'b1, 1'b0);
    send_word(REQ_RELEASE, 8'h5a);
    send_frame('{8'h05, 8'h01, 8'h7e, 8'h7d, 8'hff, 8'h00}, 1'b1, 1'b0);
    send_frame('{8'h00}, 1'b1, 1'b0);
    send_word(REQ_RELEASE, 8'ha5);

    // random phases, one station address each
    addr_set = '{8'h00, 8'hff, bsfr_pkg::FLAG_BYTE, 8'($urandom), 8'($urandom)};
    base = words_sent;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_station(addr_set[p]);
      // longest frame, then one that overruns the buffer
      if (p == 1) begin
        send_frame(build_frame(FRAME_LEN, model.station, 1'b1), 1'b1, 1'b0);
        send_word(REQ_RELEASE, 8'h00);
      end
      if (p == 2) send_frame(build_frame(FRAME_LEN + 2, model.station, 1'b1), 1'b1, 1'b0);
      run_random(base + 24 * (p + 1));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (model.errors == 0 && model.outstanding() == 0) begin
      $display("[byte_stuffed_frame_receiver_unit] OK");
    end else begin
      $display("[byte_stuffed_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
